// ----- src/fpc_pkg.sv -----
// package for the frame parser and calibrator: constants, types and register indexes
`timescale 1ns / 1ps
`default_nettype none

package fpc_pkg;

    // frame layout
    localparam int unsigned FRAME_BYTES = 34;
    localparam int unsigned CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int unsigned NUM_WORDS   = (FRAME_BYTES - 2) / 2;
    localparam int unsigned WORD_IDX_W  = $clog2(NUM_WORDS);
    localparam logic [7:0]  START_BYTE  = 8'h41;
    localparam logic [7:0]  END_BYTE    = 8'h5A;

    // word positions inside a frame
    localparam int unsigned W_RATE1  = 0;
    localparam int unsigned W_TEMP1  = 2;
    localparam int unsigned W_ACC1_0 = 3;
    localparam int unsigned W_ACC1_1 = 4;
    localparam int unsigned W_RATE0  = 5;
    localparam int unsigned W_TEMP0  = 7;
    localparam int unsigned W_ACC0_0 = 8;
    localparam int unsigned W_ACC0_1 = 9;
    localparam int unsigned W_RATE2  = 10;
    localparam int unsigned W_TEMP2  = 12;
    localparam int unsigned W_ACC2_0 = 13;
    localparam int unsigned W_ACC2_1 = 14;
    localparam int unsigned W_BATT   = 15;

    // widths
    localparam int unsigned ADC_W   = 10;
    localparam int unsigned SCALE_W = 16;
    localparam int unsigned ACC_W   = 12;
    localparam int unsigned RATE_W  = 27;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // queue between parser and calculation
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE_NULL0  = 3'd0,
        REG_RATE_NULL1  = 3'd1,
        REG_RATE_NULL2  = 3'd2,
        REG_ACCEL_NULL0 = 3'd3,
        REG_ACCEL_NULL1 = 3'd4,
        REG_ACCEL_NULL2 = 3'd5,
        REG_RATE_SCALE  = 3'd6
    } t_reg_idx;

    // reset values of the configuration
    localparam logic [ADC_W-1:0]   RATE_NULL0_RST  = 10'd480;
    localparam logic [ADC_W-1:0]   RATE_NULL1_RST  = 10'd512;
    localparam logic [ADC_W-1:0]   RATE_NULL2_RST  = 10'd480;
    localparam logic [ADC_W-1:0]   ACCEL_NULL0_RST = 10'd510;
    localparam logic [ADC_W-1:0]   ACCEL_NULL1_RST = 10'd510;
    localparam logic [ADC_W-1:0]   ACCEL_NULL2_RST = 10'd504;
    localparam logic [SCALE_W-1:0] RATE_SCALE_RST  = 16'd447;

    // calibration settings
    typedef struct packed {
        logic [ADC_W-1:0]   rate_null0;
        logic [ADC_W-1:0]   rate_null1;
        logic [ADC_W-1:0]   rate_null2;
        logic [ADC_W-1:0]   accel_null0;
        logic [ADC_W-1:0]   accel_null1;
        logic [ADC_W-1:0]   accel_null2;
        logic [SCALE_W-1:0] rate_scale;
    } t_cfg;

    // raw adc values of one good frame
    typedef struct packed {
        logic [ADC_W-1:0] rate0;
        logic [ADC_W-1:0] rate1;
        logic [ADC_W-1:0] rate2;
        logic [ADC_W-1:0] temp0;
        logic [ADC_W-1:0] temp1;
        logic [ADC_W-1:0] temp2;
        logic [ADC_W-1:0] acc0_0;
        logic [ADC_W-1:0] acc0_1;
        logic [ADC_W-1:0] acc1_0;
        logic [ADC_W-1:0] acc1_1;
        logic [ADC_W-1:0] acc2_0;
        logic [ADC_W-1:0] acc2_1;
        logic [ADC_W-1:0] batt;
    } t_raw_frame;

    // handshake between two stages
    typedef struct packed {
        logic       valid;
        t_raw_frame data;
    } t_frame_push;

endpackage

`default_nettype wire

// ----- src/imu_frame_parser_calibrator_unit.sv -----
// top level: sensor frame parser with calibration and configuration registers
//
// Bytes arrive on the rx channel (valid/ready), one per transfer. Outside a
// frame every byte other than the start byte is dropped; the start byte opens
// a 34 byte frame that is collected without resync. A frame whose last byte
// is the end marker yields one result transfer on the res channel, any other
// trailer drops the frame without a result.
// Throughput: one byte per cycle, sustained. The rx channel stalls only when
// the trailer byte arrives while the frame queue is full.
// The frame enters the queue at the trailer edge; the calibration stage works
// on the queue head and loads the result into the output register, which
// raises res valid, as soon as that register is free or being drained.
// When the receiver stalls, results wait in the output register and the
// queue (depth QUEUE_DEPTH) while bytes of the next frames keep flowing in.
// Configuration is a plain write port (enable, index, data) with no wait,
// to be used only while no frame is in flight. Reset is synchronous, active
// low: the parser goes idle, the queue and output empty, calibration
// registers return to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module imu_frame_parser_calibrator_unit
    import fpc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_rx_valid,
    output logic                        o_rx_ready,
    input  wire logic [7:0]             i_rx_byte,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                        o_res_valid,
    input  wire logic                   i_res_ready,
    output logic signed [ACC_W-1:0]     o_accel_x_sum,
    output logic signed [ACC_W-1:0]     o_accel_y_sum,
    output logic signed [ACC_W-1:0]     o_accel_z_sum,
    output logic signed [RATE_W-1:0]    o_rate_board0,
    output logic signed [RATE_W-1:0]    o_rate_board1,
    output logic signed [RATE_W-1:0]    o_rate_board2,
    output logic [ADC_W-1:0]            o_temp_board0,
    output logic [ADC_W-1:0]            o_temp_board1,
    output logic [ADC_W-1:0]            o_temp_board2,
    output logic [ADC_W-1:0]            o_battery_level
);

    t_cfg        r_cfg, n_cfg;
    t_frame_push w_push;
    t_frame_push w_head;
    logic        w_full;
    logic        w_pop;

    // configuration registers
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_RATE_NULL0:  n_cfg.rate_null0  = i_cfg_data[ADC_W-1:0];
                REG_RATE_NULL1:  n_cfg.rate_null1  = i_cfg_data[ADC_W-1:0];
                REG_RATE_NULL2:  n_cfg.rate_null2  = i_cfg_data[ADC_W-1:0];
                REG_ACCEL_NULL0: n_cfg.accel_null0 = i_cfg_data[ADC_W-1:0];
                REG_ACCEL_NULL1: n_cfg.accel_null1 = i_cfg_data[ADC_W-1:0];
                REG_ACCEL_NULL2: n_cfg.accel_null2 = i_cfg_data[ADC_W-1:0];
                REG_RATE_SCALE:  n_cfg.rate_scale  = i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_null0  <= RATE_NULL0_RST;
            r_cfg.rate_null1  <= RATE_NULL1_RST;
            r_cfg.rate_null2  <= RATE_NULL2_RST;
            r_cfg.accel_null0 <= ACCEL_NULL0_RST;
            r_cfg.accel_null1 <= ACCEL_NULL1_RST;
            r_cfg.accel_null2 <= ACCEL_NULL2_RST;
            r_cfg.rate_scale  <= RATE_SCALE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // front part
    fpc_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .i_queue_full (w_full),
        .o_push       (w_push)
    );

    // frame queue
    fpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // back part
    fpc_calc u_calc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_accel_x_sum   (o_accel_x_sum),
        .o_accel_y_sum   (o_accel_y_sum),
        .o_accel_z_sum   (o_accel_z_sum),
        .o_rate_board0   (o_rate_board0),
        .o_rate_board1   (o_rate_board1),
        .o_rate_board2   (o_rate_board2),
        .o_temp_board0   (o_temp_board0),
        .o_temp_board1   (o_temp_board1),
        .o_temp_board2   (o_temp_board2),
        .o_battery_level (o_battery_level)
    );

endmodule

`default_nettype wire

// ----- src/fpc_parser.sv -----
// front part: frame sync, byte collection and trailer check
`timescale 1ns / 1ps
`default_nettype none

module fpc_parser
    import fpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_queue_full,
    output t_frame_push      o_push
);

    logic             r_in_frame, n_in_frame;
    logic [CNT_W-1:0] r_count,    n_count;
    logic [ADC_W-1:0] r_word [NUM_WORDS];

    logic                  w_accept;
    logic                  w_last;
    logic [CNT_W-1:0]      w_half;
    logic [WORD_IDX_W-1:0] w_hi_idx;
    logic [WORD_IDX_W-1:0] w_lo_idx;

    // the trailer byte needs room in the queue, all other bytes go straight in
    assign w_last     = r_in_frame && (r_count == CNT_W'(FRAME_BYTES - 1));
    assign o_rx_ready = !(w_last && i_queue_full);
    assign w_accept   = i_rx_valid && o_rx_ready;

    // byte position to word index: odd bytes carry the high part, even the low
    assign w_half   = r_count >> 1;
    assign w_hi_idx = w_half[WORD_IDX_W-1:0];
    assign w_lo_idx = WORD_IDX_W'(w_half - CNT_W'(1));

    // sync and byte counter
    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        if (w_accept) begin
            if (!r_in_frame) begin
                if (i_rx_byte == START_BYTE) begin
                    n_in_frame = 1'b1;
                    n_count    = CNT_W'(1);
                end
            end else if (w_last) begin
                n_in_frame = 1'b0;
                n_count    = '0;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
        end
    end

    // word collection, only the low ten bits of each word are kept
    always_ff @(posedge i_clk) begin
        if (w_accept && r_in_frame && !w_last) begin
            if (r_count[0]) begin
                r_word[w_hi_idx][ADC_W-1:8] <= i_rx_byte[ADC_W-9:0];
            end else begin
                r_word[w_lo_idx][7:0] <= i_rx_byte;
            end
        end
    end

    // hand a good frame to the queue when the trailer matches
    always_comb begin
        o_push.valid       = w_accept && w_last && (i_rx_byte == END_BYTE);
        o_push.data.rate0  = r_word[W_RATE0];
        o_push.data.rate1  = r_word[W_RATE1];
        o_push.data.rate2  = r_word[W_RATE2];
        o_push.data.temp0  = r_word[W_TEMP0];
        o_push.data.temp1  = r_word[W_TEMP1];
        o_push.data.temp2  = r_word[W_TEMP2];
        o_push.data.acc0_0 = r_word[W_ACC0_0];
        o_push.data.acc0_1 = r_word[W_ACC0_1];
        o_push.data.acc1_0 = r_word[W_ACC1_0];
        o_push.data.acc1_1 = r_word[W_ACC1_1];
        o_push.data.acc2_0 = r_word[W_ACC2_0];
        o_push.data.acc2_1 = r_word[W_ACC2_1];
        o_push.data.batt   = r_word[W_BATT];
    end

endmodule

`default_nettype wire

// ----- src/fpc_queue.sv -----
// short frame queue between parser and calculation
`timescale 1ns / 1ps
`default_nettype none

module fpc_queue
    import fpc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_frame_push i_push,
    output logic             o_full,
    output t_frame_push      o_head,
    input  wire logic        i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_Q = $clog2(DEPTH + 1);

    t_raw_frame       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_Q-1:0] r_fill,   n_fill;

    logic w_wr;
    logic w_rd;

    assign o_full      = (r_fill == CNT_Q'(DEPTH));
    assign o_head.valid = (r_fill != '0);
    assign o_head.data  = r_mem[r_rd_ptr];
    assign w_wr = i_push.valid && !o_full;
    assign w_rd = i_pop && o_head.valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_wr && !w_rd) begin
            n_fill = r_fill + CNT_Q'(1);
        end else if (w_rd && !w_wr) begin
            n_fill = r_fill - CNT_Q'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

endmodule

`default_nettype wire

// ----- src/fpc_calc.sv -----
// back part: null removal, axis sums, rate scaling and the output register
`timescale 1ns / 1ps
`default_nettype none

module fpc_calc
    import fpc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire t_frame_push        i_head,
    output logic                    o_pop,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output logic signed [ACC_W-1:0]  o_accel_x_sum,
    output logic signed [ACC_W-1:0]  o_accel_y_sum,
    output logic signed [ACC_W-1:0]  o_accel_z_sum,
    output logic signed [RATE_W-1:0] o_rate_board0,
    output logic signed [RATE_W-1:0] o_rate_board1,
    output logic signed [RATE_W-1:0] o_rate_board2,
    output logic [ADC_W-1:0]         o_temp_board0,
    output logic [ADC_W-1:0]         o_temp_board1,
    output logic [ADC_W-1:0]         o_temp_board2,
    output logic [ADC_W-1:0]         o_battery_level
);

    localparam int unsigned DIFF_W = ADC_W + 1;
    localparam int unsigned PROD_W = DIFF_W + SCALE_W + 1;

    // signed difference of two unsigned adc values
    function automatic logic signed [DIFF_W-1:0] null_diff(
        input logic [ADC_W-1:0] raw,
        input logic [ADC_W-1:0] nul
    );
        null_diff = $signed({1'b0, raw}) - $signed({1'b0, nul});
    endfunction

    logic r_valid, n_valid;

    logic signed [DIFF_W-1:0] w_a0_0, w_a0_1, w_a1_0, w_a1_1, w_a2_0, w_a2_1;
    logic signed [DIFF_W-1:0] w_r0, w_r1, w_r2;
    logic signed [SCALE_W:0]  w_scale;
    logic signed [PROD_W-1:0] w_p0, w_p1, w_p2;

    // take the queue head whenever the output register is free or being drained
    assign o_pop       = i_head.valid && (!r_valid || i_res_ready);
    assign o_res_valid = r_valid;

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_res_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // null removal
    assign w_a0_0 = null_diff(i_head.data.acc0_0, i_cfg.accel_null0);
    assign w_a0_1 = null_diff(i_head.data.acc0_1, i_cfg.accel_null0);
    assign w_a1_0 = null_diff(i_head.data.acc1_0, i_cfg.accel_null1);
    assign w_a1_1 = null_diff(i_head.data.acc1_1, i_cfg.accel_null1);
    assign w_a2_0 = null_diff(i_head.data.acc2_0, i_cfg.accel_null2);
    assign w_a2_1 = null_diff(i_head.data.acc2_1, i_cfg.accel_null2);
    assign w_r0   = null_diff(i_head.data.rate0, i_cfg.rate_null0);
    assign w_r1   = null_diff(i_head.data.rate1, i_cfg.rate_null1);
    assign w_r2   = null_diff(i_head.data.rate2, i_cfg.rate_null2);

    // rate scaling, one small multiplier per board
    assign w_scale = $signed({1'b0, i_cfg.rate_scale});
    assign w_p0 = PROD_W'(w_r0) * PROD_W'(w_scale);
    assign w_p1 = PROD_W'(w_r1) * PROD_W'(w_scale);
    assign w_p2 = PROD_W'(w_r2) * PROD_W'(w_scale);

    // output register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_accel_x_sum   <= ACC_W'(w_a0_0) + ACC_W'(w_a2_1);
            o_accel_y_sum   <= ACC_W'(w_a2_0) - ACC_W'(w_a1_0);
            o_accel_z_sum   <= ACC_W'(w_a0_1) + ACC_W'(w_a1_1);
            o_rate_board0   <= w_p0[RATE_W-1:0];
            o_rate_board1   <= w_p1[RATE_W-1:0];
            o_rate_board2   <= w_p2[RATE_W-1:0];
            o_temp_board0   <= i_head.data.temp0;
            o_temp_board1   <= i_head.data.temp1;
            o_temp_board2   <= i_head.data.temp2;
            o_battery_level <= i_head.data.batt;
        end
    end

endmodule

`default_nettype wire
